// ===== hdl/ple_pkg.sv =====
package ple_pkg;

   // List storage depth and the widths that follow from it.
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // Fixed transaction field widths.
   localparam int CMD_W         = 2;
   localparam int POSITION_W    = 6;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;

   // Width used for the insert position range check.
   localparam int POS_CMP_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_POS   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      cell_op_type               op;
      logic [IDX_W-1:0]          pos_idx;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] key;
   } cell_ctl_type;

endpackage

// ===== hdl/ple_if.sv =====
interface ple_req_if import ple_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CMD_W-1:0]             cmd;
   logic [POSITION_W-1:0]        position;
   logic signed [VALUE_W-1:0]    value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic [ENTRY_COUNT_W-1:0]     entry_count;
   logic signed [VALUE_W-1:0]    entry_value;
   logic                         last;

   modport source (output valid, status, entry_count, entry_value, last, input ready);
   modport sink   (input valid, status, entry_count, entry_value, last, output ready);
endinterface

// ===== hdl/ple_cell.sv =====
module ple_cell import ple_pkg::*; (
   input  logic                      clock,
   input  logic [IDX_W-1:0]          idx,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic signed [VALUE_W-1:0] right_entry,
   input  logic signed [VALUE_W-1:0] head_entry,
   input  logic                      hit_in,
   output logic                      hit_out,
   output logic signed [VALUE_W-1:0] entry
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      in_list;
   logic [COUNT_W-1:0]        idx_wide;

   assign idx_wide = COUNT_W'(idx);
   assign in_list  = idx_wide < ctl.count;
   // The hit flag ripples along the row; it is set from the first match onwards.
   assign hit_out  = hit_in | (in_list && (entry_ff == ctl.key));
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (idx > ctl.pos_idx) begin
               entry_in = left_entry;
            end else if (idx == ctl.pos_idx) begin
               entry_in = ctl.key;
            end
         end
         OP_REMOVE: begin
            if (hit_out) begin
               entry_in = right_entry;
            end
         end
         OP_ROTATE: begin
            if (idx_wide + COUNT_W'(1) == ctl.count) begin
               entry_in = head_entry;
            end else if (in_list) begin
               entry_in = right_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/ple_chain.sv =====
module ple_chain import ple_pkg::*; (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   output logic signed [VALUE_W-1:0] head_entry,
   output logic                      found
);

   logic signed [VALUE_W-1:0] entry [DEPTH];
   logic                      hit   [DEPTH+1];

   assign hit[0]     = 1'b0;
   assign head_entry = entry[0];
   assign found      = hit[DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry;
      logic signed [VALUE_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_inner_left
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_entry = '0;
      end else begin : g_inner_right
         assign right_entry = entry[i+1];
      end

      ple_cell u_cell (
         .clock       (clock),
         .idx         (IDX_W'(i)),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .head_entry  (entry[0]),
         .hit_in      (hit[i]),
         .hit_out     (hit[i+1]),
         .entry       (entry[i])
      );
   end

endmodule

// ===== hdl/positional_list_engine.sv =====
// Channel   Direction  Contents
// req_ch    in         cmd, position, value
// rsp_ch    out        status, entry_count, entry_value, last
//
// Insert, remove and unknown commands give one transaction each. A dump of a
// non-empty list gives one transaction per entry, as the row of cells rotates by
// one place to bring the next entry to the head; no request is taken until it ends.
// Reset clears the entry count, the sequencer and the response valid flag; the
// entries themselves are not reset. A stalled response holds in its register, and
// a request is taken in the idle state whenever that register is empty or being drained.
module positional_list_engine import ple_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_ch,
   ple_rsp_if.source rsp_ch
);

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        rem_ff, rem_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [ENTRY_COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic signed [VALUE_W-1:0] entry_value_ff, entry_value_in;
   logic                      last_ff, last_in;

   cell_ctl_type              chain_ctl;
   logic signed [VALUE_W-1:0] head_entry;
   logic                      found;
   logic                      out_free;
   logic                      load;
   logic                      pos_ok;

   // The list itself: one cell per entry, each shifting to its neighbour.
   ple_chain u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .head_entry (head_entry),
      .found      (found)
   );

   // The response register may be refilled in the same cycle it is drained.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // A valid insert position lies between one and one past the current count.
   assign pos_ok = (req_ch.position != '0) &&
                   (POS_CMP_W'(req_ch.position) <= POS_CMP_W'(count_ff) + POS_CMP_W'(1));

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      rem_in            = rem_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      status_in         = status_ff;
      entry_value_in    = entry_value_ff;
      last_in           = last_ff;
      load              = 1'b0;
      req_ch.ready      = 1'b0;
      chain_ctl.op      = OP_HOLD;
      chain_ctl.pos_idx = IDX_W'(req_ch.position - POSITION_W'(1));
      chain_ctl.count   = count_ff;
      chain_ctl.key     = req_ch.value;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = out_free;
            if (req_ch.valid && out_free) begin
               load           = 1'b1;
               status_in      = STATUS_OK;
               entry_value_in = '0;
               last_in        = 1'b1;
               case (cmd_type'(req_ch.cmd))
                  CMD_INSERT: begin
                     if (!pos_ok) begin
                        status_in = STATUS_BAD_POS;
                     end else if (count_ff == COUNT_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        chain_ctl.op = OP_INSERT;
                        count_in     = count_ff + COUNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     chain_ctl.op = OP_REMOVE;
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (!found) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        // First entry goes out now; the rest follow from ST_DUMP.
                        chain_ctl.op   = OP_ROTATE;
                        entry_value_in = head_entry;
                        last_in        = (count_ff == COUNT_W'(1));
                        rem_in         = count_ff - COUNT_W'(1);
                        if (count_ff != COUNT_W'(1)) begin
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  default: status_in = STATUS_OK;
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               load           = 1'b1;
               chain_ctl.op   = OP_ROTATE;
               status_in      = STATUS_OK;
               entry_value_in = head_entry;
               last_in        = (rem_ff == COUNT_W'(1));
               rem_in         = rem_ff - COUNT_W'(1);
               if (rem_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end
      // The count shown is the count after the operation, cut to the field width.
      entry_count_in = load ? ENTRY_COUNT_W'(count_in) : entry_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
      entry_value_ff <= entry_value_in;
      last_ff        <= last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_count = entry_count_ff;
   assign rsp_ch.entry_value = entry_value_ff;
   assign rsp_ch.last        = last_ff;

   // No request is taken while a dump is still streaming entries out.
   a_dump_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> !req_ch.ready)
      else $error("request taken during dump");

   // A committed insert grows the list by exactly one entry.
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      chain_ctl.op == OP_INSERT |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not grow the list by one");

   // Only dump transactions carry an entry; failures carry zero.
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_OK |-> entry_value_ff == '0)
      else $error("failed transaction carries an entry value");

   // Leaving the dump state always coincides with the final entry being presented.
   a_dump_ends_last: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == ST_DUMP) |-> rsp_valid_ff && last_ff)
      else $error("dump ended without a last transaction");

endmodule

// ===== test/positional_list_engine_tb.sv =====
`timescale 1ns / 1ps

module positional_list_engine_tb;
   import ple_pkg::*;

   // The command field is two bits wide, but only three codes are defined.
   // The spare code must be accepted and answered with a plain OK.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   localparam int RANDOM_ITEMS = 330;

   // One response transaction as the result channel carries it.
   typedef struct packed {
      status_type                 status;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
      logic signed [VALUE_W-1:0]  entry_value;
      logic                       last;
   } list_result_type;

   // Receiver behaviour: streaming, mostly ready, mostly stalled, or a fixed pattern.
   typedef enum int {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_type;

   // Mirror of the list.  It applies every accepted request to its own copy of
   // the list, queues the responses that the request must produce, and checks
   // each response from the block against the oldest one still queued.
   class list_mirror;
      logic signed [VALUE_W-1:0] shadow[$];
      list_result_type           awaited[$];
      int                        mismatches;
      int                        checked;
      int                        peak;
      int                        cmd_seen[4];
      int                        status_seen[5];

      function void queue_result(status_type status, logic signed [VALUE_W-1:0] val,
                                 logic last);
         list_result_type r;
         r.status      = status;
         r.entry_count = ENTRY_COUNT_W'(shadow.size());   // masked to the field width
         r.entry_value = val;
         r.last        = last;
         awaited.push_back(r);
         status_seen[status]++;
      endfunction

      function void apply_request(logic [CMD_W-1:0] cmd, logic [POSITION_W-1:0] pos,
                                  logic signed [VALUE_W-1:0] val);
         int hit;
         cmd_seen[cmd]++;
         case (cmd)
            CMD_INSERT: begin
               if (pos < 1 || pos > shadow.size() + 1) begin
                  queue_result(STATUS_BAD_POS, '0, 1'b1);
               end else if (shadow.size() >= DEPTH) begin
                  queue_result(STATUS_FULL, '0, 1'b1);
               end else begin
                  shadow.insert(pos - 1, val);
                  queue_result(STATUS_OK, '0, 1'b1);
               end
            end
            CMD_REMOVE: begin
               hit = -1;
               if (shadow.size() == 0) begin
                  queue_result(STATUS_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = 0; i < shadow.size(); i++) begin
                     if (hit < 0 && shadow[i] == val) hit = i;
                  end
                  if (hit < 0) begin
                     queue_result(STATUS_NOT_FOUND, '0, 1'b1);
                  end else begin
                     shadow.delete(hit);
                     queue_result(STATUS_OK, '0, 1'b1);
                  end
               end
            end
            CMD_DUMP: begin
               if (shadow.size() == 0) begin
                  queue_result(STATUS_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = 0; i < shadow.size(); i++)
                     queue_result(STATUS_OK, shadow[i], i == shadow.size() - 1);
               end
            end
            default: queue_result(STATUS_OK, '0, 1'b1);
         endcase
         if (shadow.size() > peak) peak = shadow.size();
      endfunction

      function void compare_response(list_result_type got);
         list_result_type want;
         checked++;
         if (awaited.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected response status=%0d count=%0d value=%0d last=%0b",
                        $time, got.status, got.entry_count, got.entry_value, got.last);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (got.status !== want.status || got.entry_count !== want.entry_count ||
                got.entry_value !== want.entry_value || got.last !== want.last) begin
               if (mismatches < 10) begin
                  $display("%0t: response mismatch", $time);
                  $display("   status      expected %0d, got %0d", want.status, got.status);
                  $display("   entry_count expected %0d, got %0d", want.entry_count,
                           got.entry_count);
                  $display("   entry_value expected %0d, got %0d", want.entry_value,
                           got.entry_value);
                  $display("   last        expected %0b, got %0b", want.last, got.last);
               end
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ple_req_if req_ch ();
   ple_rsp_if rsp_ch ();

   positional_list_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_mirror mirror = new();

   // Sender burst state: transactions left in the current burst.
   int burst_left = 0;

   // Receiver stall state.
   rx_mode_type rx_mode = RX_STREAM;
   int          rx_timer = 0;
   int          rx_phase = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver picks a new behaviour each time its timer runs out, so that stalls
   // land on single responses as well as in the middle of long dumps.  The
   // streaming mode gives stretches with no back-pressure at all.
   always @(negedge clock) begin
      rx_phase <= rx_phase + 1;
      if (rx_timer == 0) begin
         rx_mode  <= rx_mode_type'($urandom_range(0, 3));
         rx_timer <= $urandom_range(20, 80);
      end else begin
         rx_timer <= rx_timer - 1;
      end
      case (rx_mode)
         RX_STREAM:  rsp_ch.ready <= 1'b1;
         RX_MOSTLY:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         RX_SPARSE:  rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ch.ready <= ((rx_phase % 7) < 4);
      endcase
   end

   // Responses are sampled at the rising edge, before the block updates them.
   always @(posedge clock) begin
      list_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status      = status_type'(rsp_ch.status);
         got.entry_count = rsp_ch.entry_count;
         got.entry_value = rsp_ch.entry_value;
         got.last        = rsp_ch.last;
         mirror.compare_response(got);
      end
   end

   // Presents one request transaction at the falling edge and holds it until it is
   // accepted.  Within a burst valid stays high from one transaction to the next;
   // when the burst runs out, valid drops for a random gap and a new burst length
   // is drawn.  Now and then a long burst gives a stretch with no gaps.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POSITION_W-1:0] pos,
                               input logic signed [VALUE_W-1:0] val);
      int gap;
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.cmd      = cmd;
      req_ch.position = pos;
      req_ch.value    = val;
      do @(posedge clock); while (!req_ch.ready);
      mirror.apply_request(cmd, pos, val);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
      end
   endtask

   // Holds the request channel idle until every queued response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
   endtask

   // Draws one random request.  In a filling phase most transactions are inserts at
   // legal positions, in a draining phase most are removes of values that are in
   // the list, so the list keeps swinging between empty and full.  Values are often
   // copied from the list so that duplicates build up and removes find a match.
   task automatic random_request(input int phase, output bit reserved);
      int                        n;
      int                        r;
      int                        ins_w;
      int                        rem_w;
      logic [POSITION_W-1:0]     pos;
      logic signed [VALUE_W-1:0] val;
      n     = mirror.shadow.size();
      r     = $urandom_range(0, 99);
      ins_w = (phase == 0) ? 60 : (phase == 1) ? 15 : 35;
      rem_w = (phase == 0) ? 15 : (phase == 1) ? 60 : 35;
      pos   = POSITION_W'($urandom);
      val   = $urandom;
      reserved = 1'b0;
      if (r < ins_w) begin
         pos = POSITION_W'($urandom_range(1, n + 1));
         case ($urandom_range(0, 9))
            0, 1, 2: if (n > 0) val = mirror.shadow[$urandom_range(0, n - 1)];
            3: val = 32'sh7FFF_FFFF;
            4: val = 32'sh8000_0000;
            5: val = ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
            default: ;
         endcase
         send_request(CMD_INSERT, pos, val);
      end else if (r < ins_w + rem_w) begin
         if (n > 0 && $urandom_range(0, 9) != 0) val = mirror.shadow[$urandom_range(0, n - 1)];
         send_request(CMD_REMOVE, pos, val);
      end else if (r < ins_w + rem_w + 14) begin
         send_request(CMD_DUMP, pos, val);
      end else if (r < 97) begin
         // A position of zero or beyond one past the end is refused.
         pos = ($urandom_range(0, 1) != 0) ? POSITION_W'(0) :
                                             POSITION_W'($urandom_range(n + 2, 63));
         send_request(CMD_INSERT, pos, val);
      end else begin
         send_request(CMD_RESERVED, pos, val);
         reserved = 1'b1;
      end
   endtask

   initial begin
      int  n;
      int  pos;
      int  accepted;
      int  phase;
      bit  reserved;
      logic signed [VALUE_W-1:0] fill_val;

      // Every input is known from time zero, while reset is held high.
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = CMD_INSERT;
      req_ch.position = '0;
      req_ch.value    = '0;
      rsp_ch.ready    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part.  On the empty list: dump, remove, inserts at position zero
      // and one past the legal end, and the spare command code.
      send_request(CMD_DUMP, 6'd0, '0);
      send_request(CMD_REMOVE, 6'd0, 32'sd5);
      send_request(CMD_INSERT, 6'd0, 32'sd1);
      send_request(CMD_INSERT, 6'd2, 32'sd1);
      send_request(CMD_RESERVED, 6'd63, -32'sd1);

      // Fill the list to capacity, inserting at the front, at the end and in the
      // middle in turn, with the extreme values and a duplicate among the entries.
      for (int i = 0; i < DEPTH; i++) begin
         n = mirror.shadow.size();
         case (i % 3)
            0:       pos = 1;
            1:       pos = n + 1;
            default: pos = n / 2 + 1;
         endcase
         case (i)
            0:       fill_val = 32'sh7FFF_FFFF;
            1:       fill_val = 32'sh8000_0000;
            2:       fill_val = 32'sd0;
            3, 4:    fill_val = -32'sd1;
            default: fill_val = $urandom;
         endcase
         send_request(CMD_INSERT, pos[POSITION_W-1:0], fill_val);
      end

      // A legal position on a full list is refused as full, a position past the
      // end as a bad position; then a dump of every entry.
      send_request(CMD_INSERT, 6'd5, 32'sd9);
      send_request(CMD_INSERT, 6'd63, 32'sd9);
      send_request(CMD_DUMP, 6'd21, '0);
      send_request(CMD_REMOVE, 6'd0, 32'sh5A5A_0001);
      send_request(CMD_REMOVE, 6'd0, -32'sd1);

      // Let the block settle completely once before the random part.
      drain_responses();

      accepted = 0;
      phase    = 0;
      while (accepted < RANDOM_ITEMS) begin
         if (accepted % 30 == 0) phase = $urandom_range(0, 2);
         random_request(phase, reserved);
         if (!reserved) accepted++;
         if ($urandom_range(0, 59) == 0) drain_responses();
      end

      drain_responses();
      repeat (40) @(posedge clock);

      if (mirror.awaited.size() != 0)
         $display("%0d expected responses never arrived", mirror.awaited.size());
      $display("Requests: %0d inserts, %0d removes, %0d dumps, %0d spare codes; %0d responses.",
               mirror.cmd_seen[CMD_INSERT], mirror.cmd_seen[CMD_REMOVE],
               mirror.cmd_seen[CMD_DUMP], mirror.cmd_seen[CMD_RESERVED], mirror.checked);
      $display("Peak fill %0d of %0d; full %0d, bad position %0d, miss %0d, empty %0d.",
               mirror.peak, DEPTH, mirror.status_seen[STATUS_FULL],
               mirror.status_seen[STATUS_BAD_POS], mirror.status_seen[STATUS_NOT_FOUND],
               mirror.status_seen[STATUS_EMPTY]);
      if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // This watchdog ends a run that hangs, with a limit far beyond what a correct run needs.
   initial begin
      #(4_000_000);
      $display("Timed out with %0d responses outstanding", mirror.awaited.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ple_pkg.sv
hdl/ple_if.sv
hdl/ple_cell.sv
hdl/ple_chain.sv
hdl/positional_list_engine.sv
test/positional_list_engine_tb.sv
